// ===== rtl/assert_macros.svh =====
// assertion macros used by the adc window average scaler
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, held off during reset
`define AWAS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, held off during reset
`define AWAS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/awas_pkg.sv =====
// shared types and constants for the adc window average scaler
`default_nettype none

package awas_pkg;

    // field widths
    localparam int CH_W     = 4;
    localparam int SAMPLE_W = 12;
    localparam int RAW_W    = 18;
    localparam int ROLE_W   = 2;
    localparam int CONV_W   = 25;
    localparam int VREF_W   = 16;
    localparam int PROD_W   = RAW_W + VREF_W;

    // parameter defaults
    localparam int DEF_CHANNELS       = 8;
    localparam int DEF_WINDOW         = 16;
    localparam int DEF_SUPPLY_CHANNEL = 3;
    localparam int DEF_TEMP_CHANNEL   = 4;
    localparam int DEF_REF_CHANNEL    = 5;

    // volts = total * 3.3 * 2^16 / (4095 * window), reduced to 360448 / 6825
    localparam int VOLT_MUL   = 360448;
    localparam int VOLT_DIV   = 6825;
    localparam int VOLT_MUL_W = $clog2(VOLT_MUL + 1);

    // role conversion constants
    localparam int ONE_Q14     = 16384;
    localparam int Q14_SHIFT   = 14;
    localparam int SUPPLY_GAIN = 11;
    localparam int TEMP_SCALE  = 100;
    localparam int TEMP_SHIFT  = 20;
    localparam int TEMP_OFFSET = 77312;
    localparam int P11_W       = PROD_W + 4;
    localparam int P100_W      = PROD_W + 7;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_EN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CORR_EN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VREF      = 2'd2;

    typedef enum logic [ROLE_W-1:0] {
        ROLE_PLAIN  = 2'd0,
        ROLE_SUPPLY = 2'd1,
        ROLE_TEMP   = 2'd2,
        ROLE_REF    = 2'd3
    } t_role;

endpackage

`default_nettype wire

// ===== rtl/awas_const_div.sv =====
// division of an unsigned total by a constant through a reciprocal multiplication, with a registered product
`default_nettype none

module awas_const_div #(
    parameter int NUM_W   = 16,
    parameter int QUO_W   = 18,
    parameter int MUL     = 360448,
    parameter int DIVISOR = 109200
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    output logic                  o_done,
    output logic [QUO_W-1:0]      o_quo
);

    typedef longint unsigned t_wide;

    // quotient = floor(num * MUL / DIVISOR) = (num * RECIP) >> SHIFT, exact for every num
    localparam int    SHIFT   = NUM_W + $clog2(DIVISOR);
    localparam t_wide RECIP   = ((t_wide'(MUL) << SHIFT) + t_wide'(DIVISOR) - t_wide'(1))
                                / t_wide'(DIVISOR);
    localparam int    RECIP_W = $clog2(RECIP + t_wide'(1));
    localparam int    PROD_W  = NUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);

    logic              r_done;
    logic [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= PROD_W'(i_num) * PROD_W'(RECIP_V);
        end
    end

    assign o_done = r_done;
    assign o_quo  = QUO_W'(r_prod >> SHIFT);

endmodule

`default_nettype wire

// ===== rtl/adc_window_average_scaler.sv =====
// adc window average scaler: per-channel moving average, volt scaling and role conversion
// a transaction runs through S_RDB, S_RDA, S_DIV, S_MUL and S_CONV to the result register
// one transaction at a time: input stalls until the sequencer is back in idle
// the result register lets the next transaction in while a result still waits
// reset: clearing pass over every address of the sample and sum memories
`default_nettype none
`include "assert_macros.svh"

module adc_window_average_scaler #(
    parameter int CHANNELS       = awas_pkg::DEF_CHANNELS,
    parameter int WINDOW         = awas_pkg::DEF_WINDOW,
    parameter int SUPPLY_CHANNEL = awas_pkg::DEF_SUPPLY_CHANNEL,
    parameter int TEMP_CHANNEL   = awas_pkg::DEF_TEMP_CHANNEL,
    parameter int REF_CHANNEL    = awas_pkg::DEF_REF_CHANNEL
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration writes
    input  wire logic                                i_cfg_we,
    input  wire logic [awas_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [awas_pkg::VREF_W-1:0]         i_cfg_data,
    // input samples
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [awas_pkg::CH_W-1:0]           i_channel,
    input  wire logic [awas_pkg::SAMPLE_W-1:0]       i_sample,
    // results
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [awas_pkg::CH_W-1:0]                o_out_channel,
    output logic [awas_pkg::RAW_W-1:0]               o_raw_volts,
    output logic [awas_pkg::ROLE_W-1:0]              o_role,
    output logic signed [awas_pkg::CONV_W-1:0]       o_converted
);

    // sizes derived from the parameters
    localparam int DEPTH   = CHANNELS * WINDOW;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CIDX_W  = $clog2(CHANNELS);
    localparam int POS_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W   = awas_pkg::SAMPLE_W + $clog2(WINDOW);
    localparam int ACC_W   = SUM_W + POS_W;
    localparam int DIVISOR = awas_pkg::VOLT_DIV * WINDOW;

    localparam logic [ADDR_W-1:0] WIN_A     = ADDR_W'(WINDOW);
    localparam logic [ADDR_W-1:0] CLR_LAST  = ADDR_W'(DEPTH - 1);
    localparam logic [SUM_W-1:0]  WIN_S     = SUM_W'(WINDOW);
    localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(WINDOW - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RDB,
        S_RDA,
        S_DIV,
        S_MUL,
        S_CONV
    } t_state;

    t_state r_state;

    // configuration registers
    logic                        r_filt_en;
    logic                        r_corr_en;
    logic [awas_pkg::VREF_W-1:0] r_vref;

    // sample ring memory and per-channel sum/pointer memory
    logic [awas_pkg::SAMPLE_W-1:0] r_win_mem [DEPTH];
    logic [ACC_W-1:0]              r_acc_mem [CHANNELS];
    logic [awas_pkg::SAMPLE_W-1:0] r_win_rdata;
    logic [ACC_W-1:0]              r_acc_rdata;

    // transaction in flight
    logic [ADDR_W-1:0]             r_clr_addr;
    logic [awas_pkg::CH_W-1:0]     r_ch;
    logic [awas_pkg::SAMPLE_W-1:0] r_smp;
    logic                          r_filt;
    logic [SUM_W-1:0]              r_sum;
    logic [POS_W-1:0]              r_pos;
    logic [ADDR_W-1:0]             r_win_addr;
    logic [SUM_W-1:0]              r_num;
    logic                          r_div_start;
    logic [awas_pkg::RAW_W-1:0]    r_raw;
    logic [awas_pkg::PROD_W-1:0]   r_prod;

    // result register
    logic                          r_o_valid;
    logic [awas_pkg::CH_W-1:0]     r_o_ch;
    logic [awas_pkg::RAW_W-1:0]    r_o_raw;
    awas_pkg::t_role               r_o_role;
    logic [awas_pkg::CONV_W-1:0]   r_o_conv;

    // combinational signals
    logic                          w_accept;
    logic                          w_in_range;
    logic                          w_ch_ok;
    logic [CIDX_W-1:0]             w_acc_raddr;
    logic [CIDX_W-1:0]             w_ch_idx;
    logic [POS_W-1:0]              w_rd_pos;
    logic [POS_W-1:0]              w_pos;
    logic [POS_W-1:0]              w_pos_next;
    logic [ADDR_W-1:0]             w_win_raddr;
    logic [SUM_W-1:0]              w_new_sum;
    logic [SUM_W-1:0]              w_total;
    logic                          w_win_we;
    logic [ADDR_W-1:0]             w_win_waddr;
    logic [awas_pkg::SAMPLE_W-1:0] w_win_wdata;
    logic                          w_acc_we;
    logic [CIDX_W-1:0]             w_acc_waddr;
    logic [ACC_W-1:0]              w_acc_wdata;
    logic                          w_div_done;
    logic [awas_pkg::RAW_W-1:0]    w_div_quo;
    logic [awas_pkg::VREF_W-1:0]   w_corr;
    logic [awas_pkg::P11_W-1:0]    w_p11;
    logic [awas_pkg::P100_W-1:0]   w_p100;
    awas_pkg::t_role               w_role;
    logic [awas_pkg::CONV_W-1:0]   w_conv;
    logic                          w_out_free;

    // only one transaction at a time: the idle state is the only one open to input
    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_out_free = !r_o_valid || !i_stall;

    // configuration register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt_en <= 1'b1;
            r_corr_en <= 1'b1;
            r_vref    <= awas_pkg::VREF_W'(awas_pkg::ONE_Q14);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                awas_pkg::CFG_FILTER_EN: r_filt_en <= i_cfg_data[0];
                awas_pkg::CFG_CORR_EN:   r_corr_en <= i_cfg_data[0];
                awas_pkg::CFG_VREF:      r_vref    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // channel checks and read addressing
    assign w_in_range  = ({1'b0, i_channel} < (awas_pkg::CH_W + 1)'(CHANNELS));
    assign w_acc_raddr = w_in_range ? i_channel[CIDX_W-1:0] : '0;
    assign w_ch_ok     = ({1'b0, r_ch} < (awas_pkg::CH_W + 1)'(CHANNELS));
    assign w_ch_idx    = w_ch_ok ? r_ch[CIDX_W-1:0] : '0;

    // ring pointer from the sum memory, wrapped if it ever lands past the window
    assign w_rd_pos    = r_acc_rdata[POS_W-1:0];
    assign w_pos       = ({1'b0, w_rd_pos} >= (POS_W + 1)'(WINDOW)) ? '0 : w_rd_pos;
    assign w_win_raddr = ADDR_W'(w_ch_idx) * WIN_A + ADDR_W'(w_pos);
    assign w_pos_next  = (r_pos == POS_LAST) ? '0 : r_pos + POS_W'(1);

    // running sum: drop the oldest sample, add the new one
    assign w_new_sum = r_sum - SUM_W'(r_win_rdata) + SUM_W'(r_smp);
    // unfiltered samples are scaled by the window so one divisor serves both paths
    assign w_total   = r_filt ? w_new_sum : SUM_W'(r_smp) * WIN_S;

    // memory write ports: clearing pass or read-modify-write of the transaction
    always_comb begin
        w_win_we    = 1'b0;
        w_win_waddr = r_win_addr;
        w_win_wdata = r_smp;
        w_acc_we    = 1'b0;
        w_acc_waddr = w_ch_idx;
        w_acc_wdata = {w_new_sum, w_pos_next};
        case (r_state)
            S_CLEAR: begin
                w_win_we    = 1'b1;
                w_win_waddr = r_clr_addr;
                w_win_wdata = '0;
                w_acc_we    = ({1'b0, r_clr_addr} < (ADDR_W + 1)'(CHANNELS));
                w_acc_waddr = r_clr_addr[CIDX_W-1:0];
                w_acc_wdata = '0;
            end
            S_RDA: begin
                w_win_we = r_filt;
                w_acc_we = r_filt;
            end
            default: ;
        endcase
    end

    // sample ring memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_win_we) begin
            r_win_mem[w_win_waddr] <= w_win_wdata;
        end
        r_win_rdata <= r_win_mem[w_win_raddr];
    end

    // per-channel sum and write pointer memory
    always_ff @(posedge i_clk) begin
        if (w_acc_we) begin
            r_acc_mem[w_acc_waddr] <= w_acc_wdata;
        end
        r_acc_rdata <= r_acc_mem[w_acc_raddr];
    end

    // volts = total * 360448 / (6825 * WINDOW), truncated
    awas_const_div #(
        .NUM_W   (SUM_W),
        .QUO_W   (awas_pkg::RAW_W),
        .MUL     (awas_pkg::VOLT_MUL),
        .DIVISOR (DIVISOR)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_num),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // role of the channel, supply first, then temperature, then reference
    always_comb begin
        if (r_ch == awas_pkg::CH_W'(SUPPLY_CHANNEL)) begin
            w_role = awas_pkg::ROLE_SUPPLY;
        end else if (r_ch == awas_pkg::CH_W'(TEMP_CHANNEL)) begin
            w_role = awas_pkg::ROLE_TEMP;
        end else if (r_ch == awas_pkg::CH_W'(REF_CHANNEL)) begin
            w_role = awas_pkg::ROLE_REF;
        end else begin
            w_role = awas_pkg::ROLE_PLAIN;
        end
    end

    // correction factor, unity when correction is off
    assign w_corr = r_corr_en ? r_vref : awas_pkg::VREF_W'(awas_pkg::ONE_Q14);

    // constant scalings of the corrected product
    assign w_p11  = awas_pkg::P11_W'(r_prod) * awas_pkg::P11_W'(awas_pkg::SUPPLY_GAIN);
    assign w_p100 = awas_pkg::P100_W'(r_prod) * awas_pkg::P100_W'(awas_pkg::TEMP_SCALE);

    always_comb begin
        case (w_role)
            awas_pkg::ROLE_SUPPLY:
                w_conv = awas_pkg::CONV_W'(w_p11 >> awas_pkg::Q14_SHIFT);
            // temperature in 2^-10 degC with the sensor offset removed
            awas_pkg::ROLE_TEMP:
                w_conv = awas_pkg::CONV_W'(w_p100 >> awas_pkg::TEMP_SHIFT)
                         - awas_pkg::CONV_W'(awas_pkg::TEMP_OFFSET);
            // reference channel passes through uncorrected
            awas_pkg::ROLE_REF:
                w_conv = awas_pkg::CONV_W'(r_raw);
            default:
                w_conv = awas_pkg::CONV_W'(r_prod >> awas_pkg::Q14_SHIFT);
        endcase
    end

    // sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_div_start <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            // a result taken while a new one is loaded is handled in the last step
            if (r_o_valid && !i_stall && r_state != S_CONV) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + ADDR_W'(1);
                    if (r_clr_addr == CLR_LAST) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_ch    <= i_channel;
                        r_smp   <= i_sample;
                        r_filt  <= r_filt_en && w_in_range;
                        r_state <= S_RDB;
                    end
                end
                // sum and pointer are out of memory: fetch the oldest sample
                S_RDB: begin
                    r_sum      <= r_acc_rdata[ACC_W-1:POS_W];
                    r_pos      <= w_pos;
                    r_win_addr <= w_win_raddr;
                    r_state    <= S_RDA;
                end
                // write back ring and sum when filtering, start the scaling division
                S_RDA: begin
                    r_num       <= w_total;
                    r_div_start <= 1'b1;
                    r_state     <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_raw   <= w_div_quo;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= awas_pkg::PROD_W'(r_raw) * awas_pkg::PROD_W'(w_corr);
                    r_state <= S_CONV;
                end
                S_CONV: begin
                    if (w_out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_ch    <= r_ch;
                        r_o_raw   <= r_raw;
                        r_o_role  <= w_role;
                        r_o_conv  <= w_conv;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_o_valid;
    assign o_out_channel = r_o_ch;
    assign o_raw_volts   = r_o_raw;
    assign o_role        = r_o_role;
    assign o_converted   = r_o_conv;

    // checks
    `AWAS_ASSERT_IMP(a_div_done_in_div, i_clk, i_rst_n, w_div_done, r_state == S_DIV)
    `AWAS_ASSERT_NXT(a_accept_reads_acc, i_clk, i_rst_n, w_accept, r_state == S_RDB)
    `AWAS_ASSERT_IMP(a_win_write_src, i_clk, i_rst_n, w_win_we,
                     r_state == S_CLEAR || (r_state == S_RDA && r_filt))
    `AWAS_ASSERT_IMP(a_result_from_conv, i_clk, i_rst_n, $rose(r_o_valid),
                     $past(r_state == S_CONV))

endmodule

`default_nettype wire

// ===== tb/adc_window_average_scaler_test.sv =====
// self-checking testbench for the adc window average scaler: directed table, then random phases
module adc_window_average_scaler_test;
    import awas_pkg::*;

    // block configuration under test
    localparam int N_CH      = DEF_CHANNELS;
    localparam int WIN       = DEF_WINDOW;
    localparam int SUPPLY_CH = DEF_SUPPLY_CHANNEL;
    localparam int TEMP_CH   = DEF_TEMP_CHANNEL;
    localparam int REF_CH    = DEF_REF_CHANNEL;

    // scaling constants, kept apart from the package so the prediction stands on its own
    localparam longint unsigned UNITY_Q14  = 16384;
    localparam longint          TEMP_ZERO  = 77312;
    localparam int              FULL_SCALE = 4095;

    // run shape
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 100;
    localparam int DIRECTED_ROWS = 22;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int MAX_REPORTS   = 10;
    localparam int TIME_LIMIT    = 4_000_000;

    typedef struct packed {
        logic [CH_W-1:0]          channel;
        logic [RAW_W-1:0]         raw_volts;
        t_role                    role;
        logic signed [CONV_W-1:0] converted;
    } scaled_result_t;

    // one row of the directed table: settings, the transaction, and an optional typed result
    typedef struct packed {
        logic                filter_en;
        logic                corr_en;
        logic [VREF_W-1:0]   vref;
        logic [CH_W-1:0]     channel;
        logic [SAMPLE_W-1:0] sample;
        logic                has_value;
        scaled_result_t      value;
    } directed_row_t;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [VREF_W-1:0]        i_cfg_data;
    logic                     i_valid;
    logic                     o_stall;
    logic [CH_W-1:0]          i_channel;
    logic [SAMPLE_W-1:0]      i_sample;
    logic                     o_valid;
    logic                     i_stall;
    logic [CH_W-1:0]          o_out_channel;
    logic [RAW_W-1:0]         o_raw_volts;
    logic [ROLE_W-1:0]        o_role;
    logic signed [CONV_W-1:0] o_converted;

    // shadow of the block: window rings, running sums, write positions and registers
    logic [SAMPLE_W-1:0] ring [N_CH][WIN];
    int unsigned         ring_sum [N_CH];
    int unsigned         ring_pos [N_CH];
    logic                filter_on;
    logic                corr_on;
    logic [VREF_W-1:0]   vref_q14;

    scaled_result_t pending_results [$];
    int             fail_count;
    bit             long_hold_req;

    directed_row_t directed [DIRECTED_ROWS] = '{
        // straight after reset: empty windows, unity correction
        '{1'b1, 1'b1, 16'd16384, 4'd0,  12'd0,    1'b1, '{4'd0, 18'd0, ROLE_PLAIN, 25'sd0}},
        '{1'b1, 1'b1, 16'd16384, 4'd4,  12'd0,    1'b1, '{4'd4, 18'd0, ROLE_TEMP, -25'sd77312}},
        // channel beyond the window store is scaled alone
        '{1'b1, 1'b1, 16'd16384, 4'd15, 12'd4095, 1'b1,
          '{4'd15, 18'd216268, ROLE_PLAIN, 25'sd216268}},
        '{1'b1, 1'b1, 16'd16384, 4'd5,  12'd4095, 1'b0, '0},
        '{1'b1, 1'b1, 16'd16384, 4'd3,  12'd4095, 1'b0, '0},
        '{1'b1, 1'b1, 16'd16384, 4'd7,  12'd2730, 1'b0, '0},
        '{1'b1, 1'b1, 16'd16384, 4'd6,  12'd1365, 1'b0, '0},
        '{1'b1, 1'b1, 16'd16384, 4'd8,  12'd4095, 1'b0, '0},
        '{1'b1, 1'b1, 16'd16384, 4'd1,  12'd4095, 1'b0, '0},
        '{1'b1, 1'b1, 16'd16384, 4'd2,  12'd2048, 1'b0, '0},
        // filtering off: full-scale sample on its own
        '{1'b0, 1'b1, 16'd16384, 4'd3,  12'd4095, 1'b1,
          '{4'd3, 18'd216268, ROLE_SUPPLY, 25'sd2378948}},
        '{1'b0, 1'b1, 16'd16384, 4'd4,  12'd4095, 1'b0, '0},
        '{1'b0, 1'b1, 16'd16384, 4'd5,  12'd4095, 1'b1,
          '{4'd5, 18'd216268, ROLE_REF, 25'sd216268}},
        // correction off with the largest factor loaded
        '{1'b1, 1'b0, 16'd65535, 4'd0,  12'd4095, 1'b0, '0},
        '{1'b1, 1'b0, 16'd65535, 4'd4,  12'd4095, 1'b0, '0},
        // largest correction factor
        '{1'b1, 1'b1, 16'd65535, 4'd3,  12'd4095, 1'b0, '0},
        '{1'b1, 1'b1, 16'd65535, 4'd4,  12'd4095, 1'b0, '0},
        '{1'b1, 1'b1, 16'd65535, 4'd0,  12'd4095, 1'b0, '0},
        // zero correction factor, reference still uncorrected
        '{1'b1, 1'b1, 16'd0,     4'd0,  12'd4095, 1'b0, '0},
        '{1'b1, 1'b1, 16'd0,     4'd4,  12'd2048, 1'b0, '0},
        '{1'b1, 1'b1, 16'd0,     4'd5,  12'd1,    1'b0, '0},
        '{1'b0, 1'b0, 16'd0,     4'd9,  12'd1,    1'b0, '0}
    };

    adc_window_average_scaler #(
        .CHANNELS       (N_CH),
        .WINDOW         (WIN),
        .SUPPLY_CHANNEL (SUPPLY_CH),
        .TEMP_CHANNEL   (TEMP_CH),
        .REF_CHANNEL    (REF_CH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_channel     (i_channel),
        .i_sample      (i_sample),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_channel (o_out_channel),
        .o_raw_volts   (o_raw_volts),
        .o_role        (o_role),
        .o_converted   (o_converted)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // averaging and role conversion for one accepted transaction, updating the shadow state
    function automatic scaled_result_t scale_sample(input logic [CH_W-1:0] ch,
                                                    input logic [SAMPLE_W-1:0] smp);
        longint unsigned volts;
        longint unsigned corr;
        longint          conv;
        int unsigned     slot;
        scaled_result_t  res;
        if (filter_on && ch < N_CH) begin
            // replace the oldest entry of this channel's window
            slot = ring_pos[ch];
            ring_sum[ch] = ring_sum[ch] - ring[ch][slot] + smp;
            ring[ch][slot] = smp;
            ring_pos[ch] = (slot + 1) % WIN;
            volts = (longint'(ring_sum[ch]) * 33 * 65536) / (longint'(40950) * WIN);
        end else begin
            // filtering off or channel outside the store: the sample alone, window of one
            volts = (longint'(smp) * 33 * 65536) / 40950;
        end
        corr = corr_on ? longint'(vref_q14) : UNITY_Q14;
        // supply takes priority over temperature, then reference
        if (ch == SUPPLY_CH) begin
            res.role = ROLE_SUPPLY;
            conv = longint'((volts * 11 * corr) / UNITY_Q14);
        end else if (ch == TEMP_CH) begin
            res.role = ROLE_TEMP;
            conv = longint'((volts * corr * 100) >> 20) - TEMP_ZERO;
        end else if (ch == REF_CH) begin
            res.role = ROLE_REF;
            conv = longint'(volts);
        end else begin
            res.role = ROLE_PLAIN;
            conv = longint'((volts * corr) / UNITY_Q14);
        end
        res.channel   = ch;
        res.raw_volts = volts[RAW_W-1:0];
        res.converted = conv[CONV_W-1:0];
        return res;
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("mismatch: %s", msg);
    endfunction

    // offer one transaction and hold it until the block takes it
    task automatic offer_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] smp,
                                input logic has_value, input scaled_result_t value);
        scaled_result_t predicted;
        i_valid   <= 1'b1;
        i_channel <= ch;
        i_sample  <= smp;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        // shadow state moves on even when the row carries its own typed result
        predicted = scale_sample(ch, smp);
        pending_results.push_back(has_value ? value : predicted);
    endtask

    // stop offering and wait until every outstanding result has come back
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // every transaction yields a result, so an empty queue means the block is idle
    task automatic load_settings(input logic f_en, input logic c_en,
                                 input logic [VREF_W-1:0] vref);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_FILTER_EN;
        i_cfg_data  <= {{(VREF_W-1){1'b0}}, f_en};
        @(posedge i_clk);
        i_cfg_index <= CFG_CORR_EN;
        i_cfg_data  <= {{(VREF_W-1){1'b0}}, c_en};
        @(posedge i_clk);
        i_cfg_index <= CFG_VREF;
        i_cfg_data  <= vref;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        filter_on = f_en;
        corr_on   = c_en;
        vref_q14  = vref;
    endtask

    // sender: reset, directed table, then random phases with bursts and gaps
    initial begin : sender
        int             burst_left;
        int             gap;
        logic [CH_W-1:0]     ch;
        logic [SAMPLE_W-1:0] smp;
        logic                f_en;
        logic                c_en;
        logic [VREF_W-1:0]   vref;

        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_FILTER_EN;
        i_cfg_data  <= '0;
        i_valid     <= 1'b0;
        i_channel   <= '0;
        i_sample    <= '0;
        fail_count    = 0;
        long_hold_req = 1'b0;
        burst_left    = 0;
        for (int c = 0; c < N_CH; c++) begin
            ring_sum[c] = 0;
            ring_pos[c] = 0;
            for (int w = 0; w < WIN; w++)
                ring[c][w] = '0;
        end
        filter_on = 1'b1;
        corr_on   = 1'b1;
        vref_q14  = VREF_W'(UNITY_Q14);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table, settings reloaded whenever a row changes them
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            if (r == 0 || directed[r].filter_en != filter_on || directed[r].corr_en != corr_on
                    || directed[r].vref != vref_q14)
                load_settings(directed[r].filter_en, directed[r].corr_en, directed[r].vref);
            offer_sample(directed[r].channel, directed[r].sample,
                         directed[r].has_value, directed[r].value);
        end

        // random phases, extremes of the settings first
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin f_en = 1'b1; c_en = 1'b1; vref = VREF_W'(UNITY_Q14); end
                1: begin f_en = 1'b1; c_en = 1'b1; vref = '1; end
                2: begin f_en = 1'b1; c_en = 1'b1; vref = '0; end
                3: begin f_en = 1'b0; c_en = 1'b1; vref = VREF_W'($urandom); end
                4: begin f_en = 1'b1; c_en = 1'b0; vref = VREF_W'($urandom); end
                default: begin
                    f_en = ($urandom_range(0, 3) != 0);
                    c_en = 1'($urandom_range(0, 1));
                    vref = VREF_W'($urandom);
                end
            endcase
            load_settings(f_en, c_en, vref);
            // receiver holds off for a long stretch while the sender keeps offering
            if (phase == 1)
                long_hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // sender pauses until everything outstanding has come back
                if (phase == 4 && n == PHASE_ITEMS / 2)
                    wait_drained();
                // mostly channels inside the store so the windows wrap many times
                if ($urandom_range(0, 99) < 85)
                    ch = CH_W'($urandom_range(0, N_CH - 1));
                else
                    ch = CH_W'($urandom_range(N_CH, (1 << CH_W) - 1));
                case ($urandom_range(0, 9))
                    0:       smp = '0;
                    1:       smp = SAMPLE_W'(FULL_SCALE);
                    default: smp = SAMPLE_W'($urandom_range(0, FULL_SCALE));
                endcase
                offer_sample(ch, smp, 1'b0, '0);
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 30);
                    if (gap > 0) begin
                        i_valid <= 1'b0;
                        repeat (gap) @(posedge i_clk);
                    end
                end
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // receiver: stall runs of random density, plus the long hold-off when asked
    initial begin : receiver
        int hold_left;
        int run_left;
        int stall_pct;
        hold_left = 0;
        run_left  = 0;
        stall_pct = 0;
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (run_left == 0) begin
                run_left = $urandom_range(1, 60);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 20;
                    2:       stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            run_left--;
            i_stall <= (hold_left > 0) || ($urandom_range(0, 99) < stall_pct);
        end
    end

    // result check against the oldest outstanding expectation
    always @(posedge i_clk) begin : check_results
        scaled_result_t want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
                note_failure($sformatf("result with nothing outstanding: ch %0d raw %0d",
                                       o_out_channel, o_raw_volts));
            end else begin
                want = pending_results.pop_front();
                if (o_out_channel !== want.channel || o_raw_volts !== want.raw_volts
                        || o_role !== want.role || o_converted !== want.converted)
                    note_failure($sformatf(
                        "exp ch %0d raw %0d role %0d conv %0d, got ch %0d raw %0d role %0d conv %0d",
                        want.channel, want.raw_volts, want.role, want.converted,
                        o_out_channel, o_raw_volts, o_role, o_converted));
            end
        end
    end

    // hard stop well beyond the slowest correct run
    initial begin
        #(TIME_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

endmodule
